### rtl/core/kli_pkg.sv
package kli_pkg;

  // command codes
  localparam logic [1:0] CMD_SET     = 2'd0;
  localparam logic [1:0] CMD_SET_KEY = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;
  localparam logic [1:0] CMD_COMPARE = 2'd3;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned FRAME_W = 10;

  // one stored frame point
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

endpackage

### rtl/core/kli_ram.sv
module kli_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/kli_div.sv
module kli_div #(
  parameter int unsigned DW = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [32:0]   dividend,
  input  logic [DW-1:0]        divisor,
  output logic signed [33:0]   quo,
  output logic [DW-1:0]        rem,
  output logic                 done
);

  localparam int unsigned NB = 33;
  localparam int unsigned CW = $clog2(NB + 1);

  logic          running;
  logic          finish;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [NB-1:0] qsh;
  logic [DW-1:0] part;
  logic [DW-1:0] dvs;
  logic [DW:0]   trial;
  logic          ge;

  // one quotient bit per cycle
  assign trial = {part, qsh[NB-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      finish  <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done   <= 1'b0;
      finish <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CW'(NB);
        neg     <= dividend[32];
        qsh     <= dividend[32] ? NB'(-dividend) : NB'(dividend);
        part    <= '0;
        dvs     <= divisor;
      end else if (running) begin
        part <= ge ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
        qsh  <= {qsh[NB-2:0], ge};
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          finish  <= 1'b1;
        end
      end
      // turn truncated magnitude into floor quotient and nonnegative remainder
      if (finish) begin
        done <= 1'b1;
        if (neg && part != '0) begin
          quo <= -($signed({1'b0, qsh}) + 34'sd1);
          rem <= dvs - part;
        end else if (neg) begin
          quo <= -$signed({1'b0, qsh});
          rem <= '0;
        end else begin
          quo <= $signed({1'b0, qsh});
          rem <= part;
        end
      end
    end
  end

endmodule

### rtl/core/keyframe_linear_interpolator.sv
// Keyframe linear interpolator: a per-frame table of Q16.16 points in one
// synchronous memory, plus a key-mark memory. Set and query commands, and any
// command with a frame out of range, answer in the cycle after start, as does
// a compare before the first key save; other compares pass through S_CMP_A,
// S_CMP_B and S_CMP_C. A key save scans the key memory for the neighbouring
// keys one frame per cycle, then refills each neighbouring span at one frame
// per cycle after a divide, or to the timeline edge if a side has no key; the
// single write port of the point memory sets that rate. After reset the key
// memory is cleared one entry per cycle, during which busy stays high. Each
// result shows for exactly one cycle with done; the receiver cannot stall.
module keyframe_linear_interpolator #(
  parameter int unsigned MAX_FRAMES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [9:0]  frame,
  input  logic [9:0]  other_frame,
  input  logic [31:0] point_x,
  input  logic [31:0] point_y,
  output logic        done,
  output logic [31:0] current_x,
  output logic [31:0] current_y,
  output logic        animated,
  output logic        frames_differ,
  output logic        range_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  localparam int unsigned AW  = $clog2(MAX_FRAMES);
  localparam int unsigned CNW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned NW  = (CNW > kli_pkg::CFG_W) ? CNW : kli_pkg::CFG_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCANP, S_SCANQ, S_KEYWR, S_SPAN_RD, S_SPAN_DAT,
    S_SPAN_DIV, S_FILL, S_CMP_A, S_CMP_B, S_CMP_C, S_DONE
  } state_t;

  state_t state;

  logic [10:0]   frame_count;
  logic [31:0]   held_x, held_y;
  logic [NW-1:0] n_eff, f_idx, g_idx, cnt, pend_addr, p_idx, q_idx;
  logic [NW-1:0] fill_end, span;
  logic          pend, p_found, q_found, fwd, flat;
  logic [AW-1:0] clr_addr;
  kli_pkg::point_t nb, cmp_pt;

  logic signed [33:0] acc_qx, acc_qy;
  logic [NW-1:0]      acc_rx, acc_ry;

  // memory ports
  logic            key_we, key_wbit, key_rbit;
  logic [AW-1:0]   key_waddr, key_raddr;
  logic            pt_we;
  logic [AW-1:0]   pt_waddr, pt_raddr;
  kli_pkg::point_t pt_wdata, pt_rdata;

  // divider lanes
  logic               div_start;
  logic signed [32:0] dx, dy;
  logic signed [33:0] dqx, dqy;
  logic [NW-1:0]      drx, dry;
  logic               donex, doney;

  logic [NW-1:0] n_now, fr_ext, of_ext;
  logic [NW:0]   rsum_x, rsum_y;
  logic          wrap_x, wrap_y;
  logic signed [31:0] va_x, va_y;

  // truncate floor quotient toward zero
  function automatic logic [31:0] trunc_out(input logic signed [33:0] q,
                                            input logic [NW-1:0] r);
    logic signed [33:0] t;
    t = (q[33] && r != '0) ? q + 34'sd1 : q;
    return t[31:0];
  endfunction

  assign busy      = state != S_IDLE;
  assign cfg_ready = 1'b1;
  assign current_x = held_x;
  assign current_y = held_y;

  // effective frame count
  always_comb begin
    if (frame_count == '0) begin
      n_now = NW'(1);
    end else if (NW'(frame_count) > NW'(MAX_FRAMES)) begin
      n_now = NW'(MAX_FRAMES);
    end else begin
      n_now = NW'(frame_count);
    end
  end

  assign fr_ext = NW'(frame);
  assign of_ext = NW'(other_frame);

  // blend step: remainder accumulate with carry into quotient
  assign rsum_x = {1'b0, acc_rx} + {1'b0, drx};
  assign rsum_y = {1'b0, acc_ry} + {1'b0, dry};
  assign wrap_x = rsum_x >= {1'b0, span};
  assign wrap_y = rsum_y >= {1'b0, span};

  assign va_x = fwd ? $signed(held_x) : $signed(nb.x);
  assign va_y = fwd ? $signed(held_y) : $signed(nb.y);

  // span delta for the dividers, taken straight from the read data
  assign div_start = state == S_SPAN_DAT;
  assign dx = fwd ? ($signed({pt_rdata.x[31], pt_rdata.x}) - $signed({held_x[31], held_x}))
                  : ($signed({held_x[31], held_x}) - $signed({pt_rdata.x[31], pt_rdata.x}));
  assign dy = fwd ? ($signed({pt_rdata.y[31], pt_rdata.y}) - $signed({held_y[31], held_y}))
                  : ($signed({held_y[31], held_y}) - $signed({pt_rdata.y[31], pt_rdata.y}));

  // memory address and write steering
  always_comb begin
    key_we    = 1'b0;
    key_waddr = f_idx[AW-1:0];
    key_wbit  = 1'b1;
    key_raddr = cnt[AW-1:0];
    pt_we     = 1'b0;
    pt_waddr  = cnt[AW-1:0];
    pt_wdata  = '{x: trunc_out(acc_qx, acc_rx), y: trunc_out(acc_qy, acc_ry)};
    pt_raddr  = f_idx[AW-1:0];
    case (state)
      S_CLEAR: begin
        key_we    = 1'b1;
        key_waddr = clr_addr;
        key_wbit  = 1'b0;
      end
      S_SCANP: begin
        key_raddr = AW'(cnt - 1'b1);
      end
      S_KEYWR: begin
        key_we   = 1'b1;
        pt_we    = 1'b1;
        pt_waddr = f_idx[AW-1:0];
        pt_wdata = '{x: held_x, y: held_y};
      end
      S_SPAN_RD: begin
        pt_raddr = fwd ? q_idx[AW-1:0] : p_idx[AW-1:0];
      end
      S_FILL: begin
        pt_we = cnt < fill_end;
      end
      S_CMP_B: begin
        pt_raddr = g_idx[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // control sequencer and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      frame_count   <= 11'd1024;
      held_x        <= '0;
      held_y        <= '0;
      animated      <= 1'b0;
      done          <= 1'b0;
      frames_differ <= 1'b0;
      range_error   <= 1'b0;
      pend          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        frame_count <= cfg_data;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(MAX_FRAMES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            n_eff         <= n_now;
            f_idx         <= fr_ext;
            g_idx         <= of_ext;
            frames_differ <= 1'b0;
            range_error   <= 1'b0;
            if (command == kli_pkg::CMD_SET || command == kli_pkg::CMD_SET_KEY) begin
              held_x <= point_x;
              held_y <= point_y;
            end
            if (command == kli_pkg::CMD_SET_KEY && fr_ext >= n_now) begin
              range_error <= 1'b1;
              done        <= 1'b1;
            end else if (command == kli_pkg::CMD_SET_KEY) begin
              animated <= 1'b1;
              cnt      <= fr_ext;
              pend     <= 1'b0;
              p_found  <= 1'b0;
              q_found  <= 1'b0;
              state    <= S_SCANP;
            end else if (command == kli_pkg::CMD_COMPARE &&
                         (fr_ext >= n_now || of_ext >= n_now)) begin
              range_error <= 1'b1;
              done        <= 1'b1;
            end else if (command == kli_pkg::CMD_COMPARE && animated) begin
              state <= S_CMP_A;
            end else begin
              done <= 1'b1;
            end
          end
        end
        // previous key, scanning down from the new key
        S_SCANP: begin
          if (pend && key_rbit) begin
            p_found <= 1'b1;
            p_idx   <= pend_addr;
            pend    <= 1'b0;
            cnt     <= f_idx + 1'b1;
            state   <= S_SCANQ;
          end else if (cnt == '0) begin
            pend  <= 1'b0;
            cnt   <= f_idx + 1'b1;
            state <= S_SCANQ;
          end else begin
            pend      <= 1'b1;
            pend_addr <= cnt - 1'b1;
            cnt       <= cnt - 1'b1;
          end
        end
        // next key, scanning up to the frame count
        S_SCANQ: begin
          if (pend && key_rbit) begin
            q_found <= 1'b1;
            q_idx   <= pend_addr;
            pend    <= 1'b0;
            state   <= S_KEYWR;
          end else if (cnt >= n_eff) begin
            pend  <= 1'b0;
            state <= S_KEYWR;
          end else begin
            pend      <= 1'b1;
            pend_addr <= cnt;
            cnt       <= cnt + 1'b1;
          end
        end
        S_KEYWR: begin
          fwd   <= 1'b1;
          state <= S_SPAN_RD;
        end
        // set up the span on the current side
        S_SPAN_RD: begin
          if (fwd ? q_found : p_found) begin
            span     <= fwd ? q_idx - f_idx : f_idx - p_idx;
            cnt      <= fwd ? f_idx + 1'b1 : p_idx + 1'b1;
            fill_end <= fwd ? q_idx : f_idx;
            state    <= S_SPAN_DAT;
          end else begin
            flat     <= 1'b1;
            acc_qx   <= 34'($signed(held_x));
            acc_qy   <= 34'($signed(held_y));
            acc_rx   <= '0;
            acc_ry   <= '0;
            cnt      <= fwd ? f_idx + 1'b1 : '0;
            fill_end <= fwd ? n_eff : f_idx;
            state    <= S_FILL;
          end
        end
        S_SPAN_DAT: begin
          nb    <= pt_rdata;
          state <= S_SPAN_DIV;
        end
        S_SPAN_DIV: begin
          if (donex) begin
            flat   <= 1'b0;
            acc_qx <= 34'(va_x) + dqx;
            acc_qy <= 34'(va_y) + dqy;
            acc_rx <= drx;
            acc_ry <= dry;
            state  <= S_FILL;
          end
        end
        // one frame written per cycle
        S_FILL: begin
          if (cnt < fill_end) begin
            cnt <= cnt + 1'b1;
            if (!flat) begin
              acc_qx <= acc_qx + dqx + (wrap_x ? 34'sd1 : 34'sd0);
              acc_qy <= acc_qy + dqy + (wrap_y ? 34'sd1 : 34'sd0);
              acc_rx <= wrap_x ? NW'(rsum_x - {1'b0, span}) : rsum_x[NW-1:0];
              acc_ry <= wrap_y ? NW'(rsum_y - {1'b0, span}) : rsum_y[NW-1:0];
            end
          end else if (fwd) begin
            fwd   <= 1'b0;
            state <= S_SPAN_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_CMP_A: begin
          state <= S_CMP_B;
        end
        S_CMP_B: begin
          cmp_pt <= pt_rdata;
          state  <= S_CMP_C;
        end
        S_CMP_C: begin
          frames_differ <= pt_rdata != cmp_pt;
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  kli_ram #(.WIDTH(1), .DEPTH(MAX_FRAMES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wbit),
    .raddr (key_raddr),
    .rdata (key_rbit)
  );

  kli_ram #(.WIDTH($bits(kli_pkg::point_t)), .DEPTH(MAX_FRAMES)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  kli_div #(.DW(NW)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dx),
    .divisor  (span),
    .quo      (dqx),
    .rem      (drx),
    .done     (donex)
  );

  kli_div #(.DW(NW)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dy),
    .divisor  (span),
    .quo      (dqy),
    .rem      (dry),
    .done     (doney)
  );

  // both divider lanes finish together
  assert property (@(posedge clk) disable iff (rst) donex == doney)
    else $error("divider lanes out of step");

  // once animated, stays animated
  assert property (@(posedge clk) disable iff (rst) $past(animated) |-> animated)
    else $error("animated flag dropped");

  // point memory is written only by key write or span fill
  assert property (@(posedge clk) disable iff (rst)
    pt_we |-> (state == S_KEYWR || state == S_FILL))
    else $error("point memory write outside key save");

  // a range error never reports a difference
  assert property (@(posedge clk) disable iff (rst)
    done && range_error |-> !frames_differ)
    else $error("range error with frames_differ set");

endmodule

### sim/keyframe_linear_interpolator_test.sv
`timescale 1ns / 100ps

module keyframe_linear_interpolator_test;

  localparam int unsigned MAX_FRAMES = 1024;
  localparam int unsigned STALL_LIMIT = 40000;

  // one answer of the block
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        animated;
    logic        differ;
    logic        range_err;
  } answer_t;

  // frame table predictor plus the queue of answers still owed
  class timeline_scoreboard;
    logic [31:0] px [MAX_FRAMES];
    logic [31:0] py [MAX_FRAMES];
    bit          key [MAX_FRAMES];
    bit          written [MAX_FRAMES];
    bit          anim;
    logic [31:0] held_x, held_y;
    logic [10:0] count_reg;
    answer_t     owed [$];
    int          mismatches;
    int          checked;

    function void clear();
      for (int i = 0; i < MAX_FRAMES; i++) begin
        key[i] = 0;
        written[i] = 0;
      end
      anim = 0;
      held_x = '0;
      held_y = '0;
      count_reg = 11'd1024;
      mismatches = 0;
      checked = 0;
    endfunction

    function int unsigned live_count();
      if (count_reg == 0) return 1;
      if (count_reg > MAX_FRAMES) return MAX_FRAMES;
      return count_reg;
    endfunction

    function logic [31:0] mix(logic [31:0] va, logic [31:0] vb, longint wa, longint wb,
                              longint span);
      longint a, b;
      a = longint'($signed(va));
      b = longint'($signed(vb));
      return 32'((a * wa + b * wb) / span);
    endfunction

    function void put(int unsigned i, logic [31:0] x, logic [31:0] y);
      px[i] = x;
      py[i] = y;
      written[i] = 1;
    endfunction

    // key save: first-key fill, then refill both neighbouring spans
    function void save_key(int unsigned f, int unsigned n);
      int p, q;
      logic [31:0] ex, ey;
      p = -1;
      q = -1;
      if (!anim) begin
        anim = 1;
        for (int unsigned i = 0; i < n; i++) put(i, held_x, held_y);
      end
      for (int i = int'(f) - 1; i >= 0; i--)
        if (key[i]) begin
          p = i;
          break;
        end
      for (int unsigned i = f + 1; i < n; i++)
        if (key[i]) begin
          q = i;
          break;
        end
      put(f, held_x, held_y);
      key[f] = 1;
      if (q < 0) begin
        for (int unsigned i = f + 1; i < n; i++) put(i, held_x, held_y);
      end else begin
        ex = px[q];
        ey = py[q];
        for (int i = f + 1; i < q; i++)
          put(i, mix(held_x, ex, q - i, i - f, q - f), mix(held_y, ey, q - i, i - f, q - f));
      end
      if (p < 0) begin
        for (int unsigned i = 0; i < f; i++) put(i, held_x, held_y);
      end else begin
        ex = px[p];
        ey = py[p];
        for (int i = p + 1; i < f; i++)
          put(i, mix(held_x, ex, i - p, f - i, f - p), mix(held_y, ey, i - p, f - i, f - p));
      end
    endfunction

    // accepted request: update the model and queue the answer
    function void note_request(logic [1:0] cmd, logic [9:0] f, logic [9:0] g,
                               logic [31:0] x, logic [31:0] y);
      answer_t a;
      int unsigned n;
      n = live_count();
      a = '0;
      if (cmd == kli_pkg::CMD_SET || cmd == kli_pkg::CMD_SET_KEY) begin
        held_x = x;
        held_y = y;
        if (cmd == kli_pkg::CMD_SET_KEY) begin
          if (f >= n) a.range_err = 1;
          else save_key(f, n);
        end
      end else if (cmd == kli_pkg::CMD_COMPARE) begin
        if (f >= n || g >= n) a.range_err = 1;
        else if (anim) a.differ = (px[f] != px[g]) || (py[f] != py[g]);
      end
      a.x = held_x;
      a.y = held_y;
      a.animated = anim;
      owed.push_back(a);
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected answer %h", got);
        return;
      end
      want = owed.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("answer mismatch: x %h/%h y %h/%h anim %b/%b differ %b/%b err %b/%b",
                   want.x, got.x, want.y, got.y, want.animated, got.animated,
                   want.differ, got.differ, want.range_err, got.range_err);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [1:0]  command = kli_pkg::CMD_QUERY;
  logic [9:0]  frame = '0;
  logic [9:0]  other_frame = '0;
  logic [31:0] point_x = '0;
  logic [31:0] point_y = '0;
  logic        done;
  logic [31:0] current_x, current_y;
  logic        animated, frames_differ, range_error;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  timeline_scoreboard sb = new();
  int idle_pct;
  int stall_cycles;
  int key_saves;
  int compares;

  keyframe_linear_interpolator #(.MAX_FRAMES(MAX_FRAMES)) dut (.*);

  always #5 clk = ~clk;

  // request and answer monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_answer({current_x, current_y, animated, frames_differ, range_error});
      if (start && !busy) sb.note_request(command, frame, other_frame, point_x, point_y);
    end
  end

  // watchdog on cycles without any traffic
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send(logic [1:0] cmd, logic [9:0] f, logic [9:0] g,
                      logic [31:0] x, logic [31:0] y);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1;
    command <= cmd;
    frame <= f;
    other_frame <= g;
    point_x <= x;
    point_y <= y;
    if (cmd == kli_pkg::CMD_SET_KEY) key_saves++;
    if (cmd == kli_pkg::CMD_COMPARE) compares++;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // let the monitor queue the last accepted request before waiting on the owed queue
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_count(logic [10:0] value);
    drain();
    cfg_valid <= 1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.count_reg = value;
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'((int'($urandom_range(200)) - 100) << 16);
      default: return $urandom;
    endcase
  endfunction

  // frame index, mostly inside the timeline, sometimes past it
  function automatic logic [9:0] pick_frame();
    int unsigned n;
    n = sb.live_count();
    if (n < MAX_FRAMES && $urandom_range(9) == 0) return 10'($urandom_range(1023, n));
    return 10'($urandom_range(n - 1));
  endfunction

  task automatic random_request();
    logic [1:0] cmd;
    logic [9:0] f, g;
    int r;
    r = $urandom_range(99);
    cmd = (r < 35) ? kli_pkg::CMD_SET_KEY : (r < 70) ? kli_pkg::CMD_COMPARE :
          (r < 85) ? kli_pkg::CMD_SET : kli_pkg::CMD_QUERY;
    f = pick_frame();
    g = ($urandom_range(3) == 0) ? f : pick_frame();
    // once animated, never compare an in-range frame that has not been written
    if (cmd == kli_pkg::CMD_COMPARE && sb.anim) begin
      if (f < sb.live_count() && !sb.written[f]) f = 0;
      if (g < sb.live_count() && !sb.written[g]) g = 0;
    end
    send(cmd, f, g, pick_coord(), pick_coord());
  endtask

  task automatic random_phase(logic [10:0] count, int items, int idle);
    write_count(count);
    idle_pct = idle;
    for (int i = 0; i < items; i++) begin
      random_request();
      // hold off once until everything owed has come back
      if (i == items / 2) drain();
    end
  endtask

  initial begin
    sb.clear();
    idle_pct = 0;
    key_saves = 0;
    compares = 0;
    repeat (12) @(posedge clk);
    rst <= 0;

    // directed: before any key, first key fill, extremes, spans and range errors
    send(kli_pkg::CMD_QUERY, 0, 0, 0, 0);
    send(kli_pkg::CMD_COMPARE, 0, 1023, 0, 0);
    send(kli_pkg::CMD_SET, 0, 0, 32'h8000_0000, 32'h7fff_ffff);
    send(kli_pkg::CMD_SET_KEY, 1023, 0, 32'h7fff_ffff, 32'h8000_0000);
    send(kli_pkg::CMD_COMPARE, 0, 1023, 0, 0);
    send(kli_pkg::CMD_SET_KEY, 0, 0, 32'h8000_0000, 32'h7fff_ffff);
    send(kli_pkg::CMD_COMPARE, 1, 1022, 0, 0);
    send(kli_pkg::CMD_SET_KEY, 512, 0, 32'hffff_ffff, 32'h0000_0001);
    send(kli_pkg::CMD_SET_KEY, 512, 0, 32'h0001_0000, 32'hfffe_8000);
    send(kli_pkg::CMD_COMPARE, 511, 513, 0, 0);
    send(kli_pkg::CMD_QUERY, 0, 0, 0, 0);
    write_count(11'd8);
    send(kli_pkg::CMD_SET_KEY, 9, 0, 32'h1234_5678, 32'h9abc_def0);
    send(kli_pkg::CMD_SET_KEY, 8, 0, 32'h0, 32'h0);
    send(kli_pkg::CMD_COMPARE, 3, 20, 0, 0);
    send(kli_pkg::CMD_COMPARE, 1023, 2, 0, 0);
    send(kli_pkg::CMD_SET_KEY, 3, 0, 32'h0005_0000, 32'hfffb_0000);
    send(kli_pkg::CMD_COMPARE, 1, 2, 0, 0);
    send(kli_pkg::CMD_COMPARE, 4, 7, 0, 0);
    write_count(11'd0);
    send(kli_pkg::CMD_SET_KEY, 0, 0, 32'h0000_ffff, 32'hffff_0000);
    send(kli_pkg::CMD_COMPARE, 0, 1, 0, 0);
    write_count(11'd2047);
    send(kli_pkg::CMD_COMPARE, 0, 1023, 0, 0);

    random_phase(11'd37, 100, 0);
    random_phase(11'd2, 80, 47);
    random_phase(11'd1024, 70, 0);
    random_phase(11'd1, 50, 19);
    random_phase(11'd300, 90, 47);
    random_phase(11'd0, 40, 0);
    random_phase(11'd16, 100, 19);
    drain();
    repeat (50) @(posedge clk);

    $display("covered %0d answers, %0d key saves, %0d compares over frame counts 0 to 2047",
             sb.checked, key_saves, compares);
    $display("sender idling at 0, 19 and 47 percent, with a full drain in every phase");
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d answers missing", sb.mismatches, sb.owed.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
